FILE: rtl/tksh_pkg.sv
// Shared types and constants for the top-k smallest heap unit.
// No dependencies; used by every module of the block.
package tksh_pkg;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [6:0] KEEP_RESET = 7'd16;

  typedef struct packed {
    logic [31:0] key;
    logic [30:0] ident;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  held_count;
    logic [31:0] worst_distance;
    logic        slot_valid;
    logic [31:0] slot_distance;
    logic [30:0] slot_index;
  } res_t;

endpackage

FILE: rtl/tksh_heap_mem.sv
// Heap entry store: one write port, two registered read ports.
// Depends on tksh_pkg for the entry type.
module tksh_heap_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tksh_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_a_addr,
  input  logic [AW-1:0]   rd_b_addr,
  output tksh_pkg::entry_t rd_a_data,
  output tksh_pkg::entry_t rd_b_data
);

  tksh_pkg::entry_t mem [DEPTH];
  tksh_pkg::entry_t rd_a_r;
  tksh_pkg::entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

FILE: rtl/tksh_ctrl.sv
// Sequencer and shared compare unit that sift entries through the heap store.
// Depends on tksh_pkg and instantiates tksh_heap_mem.
module tksh_ctrl #(
  parameter int MAX_KEEP = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       kind,
  input  logic [31:0]      distance,
  input  logic [30:0]      item_index,
  input  logic [5:0]       slot,
  input  logic [6:0]       keep_count,
  input  logic             out_free,
  output logic             busy,
  output logic             res_valid,
  output tksh_pkg::res_t   res
);

  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int LW = AW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UP   = 3'd1;
  localparam logic [2:0] ST_DOWN = 3'd2;
  localparam logic [2:0] ST_RDS  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [31:0]      worst_r, worst_nxt;
  tksh_pkg::entry_t mov_r, mov_nxt;
  logic [AW-1:0]    at_r, at_nxt;
  logic             acc_r, acc_nxt;
  logic             sval_r, sval_nxt;
  logic [31:0]      sdist_r, sdist_nxt;
  logic [30:0]      sid_r, sid_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tksh_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_a_addr, rd_b_addr;
  tksh_pkg::entry_t rd_a_data, rd_b_data;

  logic [31:0]      cap;
  logic [AW-1:0]    up_idx;
  logic [LW-1:0]    lc, rc, nlc, nrc, held;
  logic             lc_ok, rc_ok, go_l, go_r;
  tksh_pkg::entry_t cand;

  tksh_heap_mem #(
    .DEPTH (MAX_KEEP),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  assign cap    = (32'(keep_count) > 32'(MAX_KEEP)) ? 32'(MAX_KEEP) : 32'(keep_count);
  assign up_idx = (at_r - 1'b1) >> 1;
  assign held   = LW'(fill_r);
  assign lc     = {1'b0, at_r, 1'b1};
  assign rc     = LW'({1'b0, at_r, 1'b0}) + LW'(2);
  assign lc_ok  = lc < held;
  assign rc_ok  = rc < held;
  assign go_l   = lc_ok && (rd_a_data.key > mov_r.key);
  assign cand   = go_l ? rd_a_data : mov_r;
  assign go_r   = rc_ok && (rd_b_data.key > cand.key);
  assign nlc    = go_r ? LW'({rc[LW-2:0], 1'b1}) : LW'({lc[LW-2:0], 1'b1});
  assign nrc    = nlc + LW'(1);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    worst_nxt = worst_r;
    mov_nxt   = mov_r;
    at_nxt    = at_r;
    acc_nxt   = acc_r;
    sval_nxt  = sval_r;
    sdist_nxt = sdist_r;
    sid_nxt   = sid_r;
    wr_en     = 1'b0;
    wr_addr   = at_r;
    wr_data   = mov_r;
    rd_a_addr = AW'(1);
    rd_b_addr = AW'(2);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt   = 1'b0;
          sval_nxt  = 1'b0;
          sdist_nxt = '0;
          sid_nxt   = '0;
          mov_nxt   = '{key: distance, ident: item_index};
          state_nxt = ST_DONE;
          unique case (kind)
            tksh_pkg::KIND_PUSH: begin
              if (32'(fill_r) < cap) begin
                acc_nxt   = 1'b1;
                at_nxt    = AW'(fill_r);
                fill_nxt  = fill_r + 1'b1;
                rd_a_addr = AW'((fill_r - 1'b1) >> 1);
                state_nxt = ST_UP;
              end else if ((fill_r != '0) && (distance < worst_r)) begin
                acc_nxt   = 1'b1;
                at_nxt    = '0;
                state_nxt = ST_DOWN;
              end
            end
            tksh_pkg::KIND_READ: begin
              rd_a_addr = AW'(slot);
              sval_nxt  = (32'(slot) < 32'(fill_r)) && (32'(slot) < 32'(MAX_KEEP));
              state_nxt = ST_RDS;
            end
            tksh_pkg::KIND_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UP: begin
        wr_en = 1'b1;
        if ((at_r == '0) || (rd_a_data.key >= mov_r.key)) begin
          state_nxt = ST_DONE;
        end else begin
          wr_data   = rd_a_data;
          at_nxt    = up_idx;
          rd_a_addr = (up_idx - 1'b1) >> 1;
        end
      end
      ST_DOWN: begin
        wr_en = 1'b1;
        if (!go_l && !go_r) begin
          state_nxt = ST_DONE;
        end else begin
          wr_data   = go_r ? rd_b_data : rd_a_data;
          at_nxt    = go_r ? rc[AW-1:0] : lc[AW-1:0];
          rd_a_addr = nlc[AW-1:0];
          rd_b_addr = nrc[AW-1:0];
        end
      end
      ST_RDS: begin
        if (sval_r) begin
          sdist_nxt = rd_a_data.key;
          sid_nxt   = rd_a_data.ident;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (wr_en && (wr_addr == '0)) begin
      worst_nxt = wr_data.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    worst_r <= worst_nxt;
    mov_r   <= mov_nxt;
    at_r    <= at_nxt;
    acc_r   <= acc_nxt;
    sval_r  <= sval_nxt;
    sdist_r <= sdist_nxt;
    sid_r   <= sid_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign res_valid = (state_r == ST_DONE) && out_free;

  always_comb begin
    res.accepted       = acc_r;
    res.held_count     = 7'(fill_r);
    res.worst_distance = (fill_r != '0) ? worst_r : 32'd0;
    res.slot_valid     = sval_r;
    res.slot_distance  = sdist_r;
    res.slot_index     = sid_r;
  end

endmodule

FILE: rtl/top_k_smallest_heap_unit.sv
// Top level of the top-k smallest heap unit: handshake, capacity register, result register.
// Depends on tksh_pkg and instantiates tksh_ctrl.
//
// Keeps the keep_count smallest (distance, index) candidates in a binary max-heap held
// in a two-read, one-write memory, with the largest kept distance at the root. Items are
// taken one at a time: in_stall stays high from acceptance until the result has been
// loaded into the output register, which then holds it while the next item is taken.
// A push that appends sifts the entry up and a push that replaces the root sifts it down,
// through the L heap levels the entry moves (at most log2 of MAX_KEEP, six at the default
// depth): each level is one read of the parent or both children, one compare and one write
// of the heap memory, plus one final write of the entry. A read fetches one slot of the
// memory, and a clear or a dropped push writes no entry. Write keep_count only while idle,
// and clear the heap after changing it.
module top_k_smallest_heap_unit #(
  parameter int MAX_KEEP = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_distance,
  input  logic [30:0] in_item_index,
  input  logic [5:0]  in_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [6:0]  out_held_count,
  output logic [31:0] out_worst_distance,
  output logic        out_slot_valid,
  output logic [31:0] out_slot_distance,
  output logic [30:0] out_slot_index
);

  logic [6:0]     keep_r;
  logic           out_valid_r;
  tksh_pkg::res_t out_r;
  tksh_pkg::res_t res;
  logic           busy, res_valid, out_free, start;

  assign out_free = !out_valid_r || !out_stall;
  assign start    = in_valid && !busy;
  assign in_stall = busy;

  tksh_ctrl #(
    .MAX_KEEP (MAX_KEEP)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_kind),
    .distance   (in_distance),
    .item_index (in_item_index),
    .slot       (in_slot),
    .keep_count (keep_r),
    .out_free   (out_free),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= tksh_pkg::KEEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_r.accepted;
  assign out_held_count     = out_r.held_count;
  assign out_worst_distance = out_r.worst_distance;
  assign out_slot_valid     = out_r.slot_valid;
  assign out_slot_distance  = out_r.slot_distance;
  assign out_slot_index     = out_r.slot_index;

endmodule
